@@ hw/rtl/fmss_pkg.sv @@
`default_nettype none

package fmss_pkg;

    // item command codes
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TEXT = 1'b1
    } t_cmd;

    // field widths fixed by the interface
    localparam int BYTE_W     = 8;
    localparam int SLOT_W     = 5;
    localparam int LEN_REG_W  = 6;
    localparam int POS_OUT_W  = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index, taken from the word address bit
    localparam logic REG_PATTERN_LENGTH = 1'b0;

    // per-cycle control handed to every cell of the row
    typedef struct packed {
        logic shift;    // a text byte enters, window moves one cell
        logic rotate;   // pattern ring moves one cell toward cell 0
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ hw/rtl/first_match_string_search_core.sv @@
`default_nettype none

// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+------------------------------------------
// item in   | in        | i_valid / o_ready  | i_command i_data_byte i_pattern_slot
//           |           |                    | i_last_text
// result    | out       | o_valid / i_ready  | o_found o_match_position
// register  | in/out    | psel penable pready| paddr pwrite pwdata prdata
//
// one item per cycle: every text byte shifts the window row and the match is
// decided in the same cycle by the per-cell byte compares and one wide AND
// a result is registered on the last text byte and shows the next cycle; the
// input stalls while a result is held and not taken, and takes the next item
// in the cycle the result leaves
// after a pattern_length write the pattern ring realigns one cell per cycle,
// with o_ready low until it is aligned (register writes still taken)
// reset is synchronous, active low; pattern bytes are not cleared
module first_match_string_search_core #(
    parameter int MAX_PATTERN   = 32,
    parameter int POSITION_BITS = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // item channel
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire                                 i_command,
    input  wire [fmss_pkg::BYTE_W-1:0]          i_data_byte,
    input  wire [fmss_pkg::SLOT_W-1:0]          i_pattern_slot,
    input  wire                                 i_last_text,
    // result channel
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic                                o_found,
    output logic [fmss_pkg::POS_OUT_W-1:0]      o_match_position,
    // register port
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [fmss_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire [fmss_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [fmss_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    // ring index width, length compare width, load index width, counter width
    localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W  = (LEN_W > fmss_pkg::LEN_REG_W) ? LEN_W : fmss_pkg::LEN_REG_W;
    localparam int IW     = ((PIDX_W > fmss_pkg::SLOT_W) ? PIDX_W : fmss_pkg::SLOT_W) + 1;
    localparam int CNT_W  = POSITION_BITS + 1;

    // ---------------------------------------------------------------- registers
    logic [fmss_pkg::LEN_REG_W-1:0] r_len;        // pattern_length register
    logic [PIDX_W-1:0]              r_base;       // cell 0 holds pattern[r_base]
    logic [CNT_W-1:0]               r_seen;       // text bytes in this stream
    logic                           r_match;      // first match fixed
    logic [POSITION_BITS-1:0]       r_first;      // its start offset
    logic                           r_out_valid;
    logic                           r_out_found;
    logic [fmss_pkg::POS_OUT_W-1:0] r_out_pos;

    // ------------------------------------------------------- register port
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        if (paddr[2] == fmss_pkg::REG_PATTERN_LENGTH) begin
            prdata = fmss_pkg::APB_DATA_W'(r_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= fmss_pkg::LEN_REG_W'(1);
        end else if (cfg_wr && paddr[2] == fmss_pkg::REG_PATTERN_LENGTH) begin
            r_len <= pwdata[fmss_pkg::LEN_REG_W-1:0];
        end
    end

    // ------------------------------------------------------ used length
    // zero is taken as one, anything above the row length as the row length
    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  used_len;
    logic [PIDX_W-1:0] target_base;
    logic              rotating;

    assign len_ext = CMP_W'(r_len);

    always_comb begin
        priority if (len_ext == '0) begin
            used_len = CMP_W'(1);
        end else if (len_ext > CMP_W'(MAX_PATTERN)) begin
            used_len = CMP_W'(MAX_PATTERN);
        end else begin
            used_len = len_ext;
        end
    end

    // the ring is aligned when cell 0 holds the last used pattern byte
    assign target_base = PIDX_W'(used_len - CMP_W'(1));
    assign rotating    = (r_base != target_base);

    // ---------------------------------------------------------- handshake
    logic acc;
    logic acc_text;
    logic acc_load;

    assign o_ready  = !rotating && (!r_out_valid || i_ready);
    assign acc      = i_valid && o_ready;
    assign acc_text = acc && (i_command == fmss_pkg::CMD_TEXT);
    assign acc_load = acc && (i_command == fmss_pkg::CMD_LOAD);

    // ------------------------------------------------------ pattern load
    // slot s sits in cell (r_base - s) mod MAX_PATTERN
    logic [IW-1:0]     slot_ext;
    logic [IW-1:0]     base_ext;
    logic [IW-1:0]     load_cell_ext;
    logic [PIDX_W-1:0] load_cell;
    logic              slot_ok;

    assign slot_ext = IW'(i_pattern_slot);
    assign base_ext = IW'(r_base);
    assign slot_ok  = slot_ext < IW'(MAX_PATTERN);

    always_comb begin
        if (base_ext >= slot_ext) begin
            load_cell_ext = base_ext - slot_ext;
        end else begin
            load_cell_ext = base_ext + IW'(MAX_PATTERN) - slot_ext;
        end
    end

    assign load_cell = load_cell_ext[PIDX_W-1:0];

    // ring alignment: one cell per cycle, base steps down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (rotating) begin
            if (r_base == '0) begin
                r_base <= PIDX_W'(MAX_PATTERN - 1);
            end else begin
                r_base <= r_base - PIDX_W'(1);
            end
        end
    end

    // -------------------------------------------------------- cell row
    fmss_pkg::t_cell_ctrl        cell_ctrl;
    logic [fmss_pkg::BYTE_W-1:0] w_text [MAX_PATTERN];
    logic [fmss_pkg::BYTE_W-1:0] w_pat  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]      cell_ok;
    logic                        window_hit;

    assign cell_ctrl.shift  = acc_text;
    assign cell_ctrl.rotate = rotating;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [fmss_pkg::BYTE_W-1:0] text_in;
        logic                        eq;
        logic                        active;
        logic                        load_here;

        if (k == 0) begin : g_head
            assign text_in = i_data_byte;
        end else begin : g_body
            assign text_in = w_text[k-1];
        end

        assign active    = CMP_W'(k) < used_len;
        assign load_here = acc_load && slot_ok && (load_cell == PIDX_W'(k));

        fmss_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (cell_ctrl),
            .i_load      (load_here),
            .i_load_byte (i_data_byte),
            .i_text      (text_in),
            .i_pat       (w_pat[(k + 1) % MAX_PATTERN]),
            .o_text      (w_text[k]),
            .o_pat       (w_pat[k]),
            .o_eq        (eq)
        );

        // cells past the used length do not take part
        assign cell_ok[k] = eq || !active;
    end

    assign window_hit = &cell_ok;

    // --------------------------------------------------- stream state
    logic [CNT_W-1:0] seen_inc;
    logic [CNT_W-1:0] used_cnt;
    logic [CNT_W-1:0] start;
    logic             exact;
    logic             take;

    assign exact    = (r_seen != '1);           // counter has not saturated
    assign seen_inc = r_seen + CNT_W'(1);
    assign used_cnt = CNT_W'(used_len);
    assign start    = seen_inc - used_cnt;

    // short text, far start and saturation all block a new match
    assign take = exact && !r_match && (seen_inc >= used_cnt)
                  && !start[CNT_W-1] && window_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_match <= 1'b0;
            r_first <= '0;
        end else if (acc_text) begin
            if (i_last_text) begin
                // stream done: clear for the next one
                r_seen  <= '0;
                r_match <= 1'b0;
                r_first <= '0;
            end else begin
                if (exact) begin
                    r_seen <= seen_inc;
                end
                if (take) begin
                    r_match <= 1'b1;
                    r_first <= start[POSITION_BITS-1:0];
                end
            end
        end
    end

    // ---------------------------------------------------- result register
    logic [POSITION_BITS-1:0] n_pos;

    always_comb begin
        priority if (take) begin
            n_pos = start[POSITION_BITS-1:0];
        end else if (r_match) begin
            n_pos = r_first;
        end else begin
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc_text && i_last_text) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_text && i_last_text) begin
            r_out_found <= r_match || take;
            r_out_pos   <= fmss_pkg::POS_OUT_W'(n_pos);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_found          = r_out_found;
    assign o_match_position = r_out_pos;

endmodule

`default_nettype wire

@@ hw/rtl/fmss_cell.sv @@
`default_nettype none

// one cell: a window byte moving away from the entry point and a pattern
// byte on a ring; compares the byte entering the window with its pattern byte
module fmss_cell (
    input  wire                          i_clk,
    input  wire fmss_pkg::t_cell_ctrl    i_ctrl,
    input  wire                          i_load,
    input  wire [fmss_pkg::BYTE_W-1:0]   i_load_byte,
    input  wire [fmss_pkg::BYTE_W-1:0]   i_text,
    input  wire [fmss_pkg::BYTE_W-1:0]   i_pat,
    output logic [fmss_pkg::BYTE_W-1:0]  o_text,
    output logic [fmss_pkg::BYTE_W-1:0]  o_pat,
    output logic                         o_eq
);

    logic [fmss_pkg::BYTE_W-1:0] r_text;
    logic [fmss_pkg::BYTE_W-1:0] r_pat;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_text <= i_text;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctrl.rotate) begin
            r_pat <= i_pat;
        end else if (i_load) begin
            r_pat <= i_load_byte;
        end else begin
            r_pat <= r_pat;
        end
    end

    assign o_text = r_text;
    assign o_pat  = r_pat;
    // compare against the byte this cell holds after the shift
    assign o_eq   = (i_text == r_pat);

endmodule

`default_nettype wire

@@ hw/rtl/fmss_checker.sv @@
`default_nettype none

module fmss_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_valid,
    input wire                              o_ready,
    input wire                              i_command,
    input wire [fmss_pkg::BYTE_W-1:0]       i_data_byte,
    input wire [fmss_pkg::SLOT_W-1:0]       i_pattern_slot,
    input wire                              i_last_text,
    input wire                              o_valid,
    input wire                              i_ready,
    input wire                              o_found,
    input wire [fmss_pkg::POS_OUT_W-1:0]    o_match_position
);

    logic acc_text_last;
    logic acc_load;

    assign acc_text_last = i_valid && o_ready && (i_command == fmss_pkg::CMD_TEXT)
                           && i_last_text;
    assign acc_load      = i_valid && o_ready && (i_command == fmss_pkg::CMD_LOAD);

    // held result keeps its payload until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found) && $stable(o_match_position))
        else $error("result changed while stalled");

    // a miss reports offset zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_match_position == '0)
        else $error("not found with nonzero position");

    // the last text byte of a stream always yields a result next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_text_last |=> o_valid)
        else $error("missing result after last text byte");

    // a pattern load never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_load |=> !o_valid)
        else $error("result after pattern load");

    // a new result appears only after a last text byte
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(acc_text_last))
        else $error("result without a last text byte");

endmodule

bind first_match_string_search_core fmss_checker u_fmss_checker (.*);

`default_nettype wire
